// ----- sv/itrd_pkg.sv -----
// ----------------------------------------------------------------------------
// itrd_pkg: shared types and constants for integer_to_radix_digits
// Result status codes, controller states, divider status and the digit
// character table.
// ----------------------------------------------------------------------------
package itrd_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_BADRADIX = 2'd2
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_READ,
    S_EMIT
  } state_t;

  // divider status toward the controller
  typedef struct packed {
    logic       done;
    logic [3:0] rem;
  } div_stat_t;

  localparam int RADIX_BITS = 5;
  localparam int DIGIT_BITS = 4;
  localparam int CHAR_BITS  = 7;

  localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 5'd16;
  localparam logic [RADIX_BITS-1:0] RADIX_RESET = 5'd10;

  // "0123456789abcdef"
  localparam logic [CHAR_BITS-1:0] DIGIT_CHARS [16] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
  };

endpackage

// ----- sv/itrd_ram.sv -----
// ----------------------------------------------------------------------------
// itrd_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module itrd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/itrd_div.sv -----
// ----------------------------------------------------------------------------
// itrd_div: bit-serial restoring divider
// Divides an unsigned dividend by a small radix, one quotient bit per cycle,
// most significant bit first. Done pulses for one cycle once the quotient and
// remainder have settled; both then hold until the next start.
// ----------------------------------------------------------------------------
module itrd_div
  import itrd_pkg::*;
#(
  parameter int QW = 31
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [QW-1:0]         dividend,
  input  logic [RADIX_BITS-1:0] radix,
  output logic [QW-1:0]         quotient,
  output div_stat_t             stat
);

  localparam int CW = $clog2(QW + 1);

  logic [QW-1:0]         quot_r, quot_nxt;
  logic [DIGIT_BITS-1:0] rem_r, rem_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic [RADIX_BITS-1:0] trial;
  logic [RADIX_BITS-1:0] diff;
  logic                  ge;
  logic                  done;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_r, quot_r[QW-1]};
  assign ge    = (trial >= radix);
  assign diff  = trial - radix;
  assign done  = busy_r && (cnt_r == '0);

  always_comb begin
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      quot_nxt = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CW'(QW);
      busy_nxt = 1'b1;
    end else if (busy_r && (cnt_r != '0)) begin
      quot_nxt = {quot_r[QW-2:0], ge};
      rem_nxt  = ge ? diff[DIGIT_BITS-1:0] : trial[DIGIT_BITS-1:0];
      cnt_nxt  = cnt_r - 1'b1;
    end else if (done) begin
      busy_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
  end

  assign quotient  = quot_r;
  assign stat.done = done;
  assign stat.rem  = rem_r;

endmodule

// ----- sv/integer_to_radix_digits.sv -----
// ----------------------------------------------------------------------------
// integer_to_radix_digits: signed integer to ASCII digits in radix 2..16
// Converts one value into lower-case digit characters, most significant
// digit first, one output transaction per digit, last on the final one.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes one value per transaction.
//   Output channel (out_valid/out_stall) gives digit_char, last, status.
//   cfg_radix is written over cfg_valid/cfg_ready (always ready) while idle.
//   A radix outside 2..16 gives one result with status invalid radix; a
//   value of zero or below gives one result with status empty.
// Timing:
//   Special cases: the result is registered in the cycle after acceptance.
//   Otherwise each digit costs one pass of a bit-serial divider (a load, then
//   one quotient bit per cycle), and each digit then leaves through the digit
//   RAM read port in a read state and then an emit state. One value is worked
//   on at a time; in_stall is high until the last digit has been loaded into
//   the output register and that register can take a new result.
// Reset and stall:
//   Reset sets radix to 10 and empties the output register; the digit RAM
//   needs no clearing. A stalled output holds its transaction and the
//   controller waits before emitting the next digit.
// ----------------------------------------------------------------------------
module integer_to_radix_digits
  import itrd_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  parameter int MAX_DIGITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [VALUE_BITS-1:0] in_value,
  // output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [CHAR_BITS-1:0]         out_digit_char,
  output logic                         out_last,
  output logic [1:0]                   out_status,
  // configuration
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [RADIX_BITS-1:0]        cfg_radix
);

  localparam int QW = VALUE_BITS - 1;
  localparam int AW = $clog2(MAX_DIGITS);
  localparam int CW = $clog2(MAX_DIGITS + 1);

  state_t                state_r, state_nxt;
  logic [RADIX_BITS-1:0] radix_r;
  logic [CW-1:0]         cnt_r, cnt_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [CHAR_BITS-1:0]  out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;
  status_t               out_status_r, out_status_nxt;

  logic                  slot_free;
  logic                  in_accept;
  logic                  radix_bad;
  logic                  value_bad;
  logic                  quot_zero;
  logic                  out_load;

  logic                  div_start;
  logic [QW-1:0]         div_dividend;
  logic [QW-1:0]         div_quot;
  div_stat_t             div_stat;

  logic                  ram_we;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [DIGIT_BITS-1:0] ram_rdata;
  logic [CW-1:0]         cnt_dec;

  // handshake and checks
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == S_IDLE) && slot_free);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign radix_bad = (radix_r < RADIX_MIN) || (radix_r > RADIX_MAX);
  assign value_bad = in_value[VALUE_BITS-1] || (in_value == '0);
  assign quot_zero = (div_quot == '0);
  assign cnt_dec   = cnt_r - 1'b1;
  assign ram_raddr = cnt_dec[AW-1:0];

  // digit divider
  itrd_div #(
    .QW (QW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .radix    (radix_r),
    .quotient (div_quot),
    .stat     (div_stat)
  );

  // remainder store, least significant digit at address 0
  itrd_ram #(
    .WIDTH (DIGIT_BITS),
    .DEPTH (MAX_DIGITS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (div_stat.rem),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept && !radix_bad && !value_bad) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done && quot_zero) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          state_nxt = (cnt_r == CW'(1)) ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // controller outputs and datapath control
  always_comb begin
    div_start      = 1'b0;
    div_dividend   = in_value[QW-1:0];
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    cnt_nxt        = cnt_r;
    out_load       = 1'b0;
    out_char_nxt   = out_char_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (radix_bad) begin
            out_load       = 1'b1;
            out_char_nxt   = '0;
            out_last_nxt   = 1'b1;
            out_status_nxt = ST_BADRADIX;
          end else if (value_bad) begin
            out_load       = 1'b1;
            out_char_nxt   = '0;
            out_last_nxt   = 1'b1;
            out_status_nxt = ST_EMPTY;
          end else begin
            div_start = 1'b1;
            cnt_nxt   = '0;
          end
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          // keep only the MAX_DIGITS least significant digits
          ram_we = (cnt_r < CW'(MAX_DIGITS));
          if (ram_we) begin
            cnt_nxt = cnt_r + 1'b1;
          end
          if (!quot_zero) begin
            div_start    = 1'b1;
            div_dividend = div_quot;
          end
        end
      end
      S_READ: begin
        ram_re = 1'b1;
      end
      S_EMIT: begin
        if (slot_free) begin
          out_load       = 1'b1;
          out_char_nxt   = DIGIT_CHARS[ram_rdata];
          out_last_nxt   = (cnt_r == CW'(1));
          out_status_nxt = ST_OK;
          cnt_nxt        = cnt_dec;
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  // output register valid
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      radix_r     <= RADIX_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        radix_r <= cfg_radix;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    out_char_r   <= out_char_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last       = out_last_r;
  assign out_status     = out_status_r;

endmodule

// ----- tb/radix_digits_checker.sv -----
// ----------------------------------------------------------------------------
// radix_digits_checker: scoreboard for integer_to_radix_digits
// Watches the configuration, input and result channels. Each accepted input
// transaction is expanded into the digit transactions that should follow.
// Each accepted result is compared field by field against the oldest
// expected one. The failure count and the number of expected results still
// waiting are handed to the testbench top.
// ----------------------------------------------------------------------------
module radix_digits_checker
  import itrd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic signed [31:0]    in_value,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [CHAR_BITS-1:0]  out_digit_char,
  input  logic                  out_last,
  input  logic [1:0]            out_status,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [RADIX_BITS-1:0] cfg_radix,
  output int                    fail_count,
  output int                    pending
);

  typedef struct {
    logic [CHAR_BITS-1:0] digit_char;
    logic                 last;
    status_t              status;
  } digit_result_t;

  digit_result_t         expected_digits[$];
  logic [RADIX_BITS-1:0] radix_q;

  // one printed line per mismatch
  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // expand one value into its expected digit transactions
  function automatic void predict_digits(input logic [31:0] value,
                                         input logic [RADIX_BITS-1:0] base);
    logic [3:0]    digits [32];
    logic [31:0]   rest;
    int            n;
    digit_result_t r;
    n = 0;
    r.digit_char = '0;
    r.last       = 1'b1;
    // radix check wins over the value check
    if (base < RADIX_MIN || base > RADIX_MAX) begin
      r.status = ST_BADRADIX;
      expected_digits.push_back(r);
      return;
    end
    if (value[31] || value == '0) begin
      r.status = ST_EMPTY;
      expected_digits.push_back(r);
      return;
    end
    // remainders, least significant first
    rest = value;
    while (rest != '0) begin
      digits[n] = 4'(rest % 32'(base));
      rest      = rest / 32'(base);
      n++;
    end
    // emitted most significant first; 'a' - 10 is 7'h57
    for (int i = n - 1; i >= 0; i--) begin
      r.digit_char = (digits[i] < 4'd10) ? 7'h30 + 7'(digits[i])
                                         : 7'h57 + 7'(digits[i]);
      r.last       = (i == 0);
      r.status     = ST_OK;
      expected_digits.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    digit_result_t exp_r;
    if (!rst_n) begin
      expected_digits.delete();
      radix_q = RADIX_RESET;
    end else begin
      if (cfg_valid && cfg_ready)
        radix_q = cfg_radix;
      // result transaction
      if (out_valid && !out_stall) begin
        if (expected_digits.size() == 0) begin
          report_mismatch($sformatf("result char=%h last=%b status=%0d with nothing expected",
                                    out_digit_char, out_last, out_status));
        end else begin
          exp_r = expected_digits.pop_front();
          if (out_digit_char !== exp_r.digit_char)
            report_mismatch($sformatf("digit_char %h, expected %h",
                                      out_digit_char, exp_r.digit_char));
          if (out_last !== exp_r.last)
            report_mismatch($sformatf("last %b, expected %b", out_last, exp_r.last));
          if (out_status !== 2'(exp_r.status))
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_status, exp_r.status));
        end
      end
      // input transaction
      if (in_valid && !in_stall)
        predict_digits(in_value, radix_q);
    end
    pending = expected_digits.size();
  end

endmodule

// ----- tb/tb_integer_to_radix_digits.sv -----
// ----------------------------------------------------------------------------
// tb_integer_to_radix_digits: testbench top for integer_to_radix_digits
// Drives a directed set of values and radices (extremes, every digit
// character, empty and invalid-radix cases), then random values over a
// sequence of radix settings with random idling on both channels and one
// long receiver hold. Checking is done by radix_digits_checker.
// ----------------------------------------------------------------------------
module tb_integer_to_radix_digits
  import itrd_pkg::*;
;

  localparam int IDLE_LIMIT    = 20000;
  localparam int HOLD_CYCLES   = 2000;
  localparam int PHASE_COUNT   = 10;
  localparam int PHASE_ITEMS   = 9;
  localparam logic [RADIX_BITS-1:0] PHASE_RADIX [PHASE_COUNT] = '{
    5'd2, 5'd16, 5'd31, 5'd3, 5'd10, 5'd0, 5'd8, 5'd17, 5'd1, 5'd7
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic signed [31:0]    in_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CHAR_BITS-1:0]  out_digit_char;
  logic                  out_last;
  logic [1:0]            out_status;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [RADIX_BITS-1:0] cfg_radix = '0;

  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  integer_to_radix_digits u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_digit_char (out_digit_char),
    .out_last       (out_last),
    .out_status     (out_status),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_radix      (cfg_radix)
  );

  radix_digits_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_digit_char (out_digit_char),
    .out_last       (out_last),
    .out_status     (out_status),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_radix      (cfg_radix),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // receiver: random stall, or a long hold when one is requested
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // watchdog: cycles with no transaction on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one value, with random idle cycles in front, until accepted
  task automatic send_value(input logic signed [31:0] v);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (in_stall);
  endtask

  // stop offering and wait until every expected result has come
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // radix write, only with the block idle
  task automatic set_radix(input logic [RADIX_BITS-1:0] r);
    drain();
    cfg_valid <= 1'b1;
    cfg_radix <= r;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly positive values of random length, some zero and negative
  function automatic logic signed [31:0] pick_value();
    int          width;
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = {1'b1, 31'($urandom)};
      2: v = $urandom;
      default: begin
        width = $urandom_range(1, 31);
        v = $urandom & ((32'd1 << width) - 32'd1);
        if (v == '0)
          v = 32'd1;
      end
    endcase
    return v;
  endfunction

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 35;
    recv_idle_pct = 78;

    // directed: reset radix of 10
    send_value(32'sd0);
    send_value(32'sd1);
    send_value(-32'sd1);
    send_value(32'sh7fffffff);
    send_value(32'sh80000000);
    send_value(32'sd9);
    send_value(32'sd10);
    // radix 2: longest conversions
    set_radix(5'd2);
    send_value(32'sd1);
    send_value(32'sd2);
    send_value(32'sh7fffffff);
    send_value(32'sh55555555);
    // radix 16: digit characters 1 to f
    set_radix(5'd16);
    send_value(32'sh7fedcba9);
    send_value(32'sh12345678);
    send_value(32'sd15);
    // invalid radices, also with a value that would be empty
    set_radix(5'd0);
    send_value(32'sd5);
    set_radix(5'd1);
    send_value(32'sd5);
    set_radix(5'd17);
    send_value(32'sd5);
    send_value(32'sd0);
    set_radix(5'd31);
    send_value(-32'sd1);
    set_radix(5'd3);
    send_value(32'sh7fffffff);

    // random phases over several radix settings
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      set_radix(PHASE_RADIX[ph]);
      if (ph < 4) begin
        send_idle_pct = 35;
        recv_idle_pct = 78;
      end else if (ph < 7) begin
        send_idle_pct = 78;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // long receiver hold while values keep coming
      if (ph == 3)
        hold_req <= hold_req + 1;
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_value(pick_value());
    end

    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
